FILE: hdl/apmq_pkg.sv
// ----------------------------------------------------------------------------
// apmq_pkg: shared types and constants for the alarm priority message queue
// Queue geometry, status codes and the request and response records.
// ----------------------------------------------------------------------------
package apmq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PAYLOAD_WIDTH = 32;

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int HELD_W  = 5;
	localparam int STAT_W  = 3;

	localparam logic OP_SEND    = 1'b0;
	localparam logic OP_RECEIVE = 1'b1;

	localparam logic KIND_NORMAL = 1'b0;
	localparam logic KIND_ALARM  = 1'b1;

	localparam logic [STAT_W-1:0] ST_SENT       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_ROOM    = 3'd1;
	localparam logic [STAT_W-1:0] ST_GOT_NORMAL = 3'd2;
	localparam logic [STAT_W-1:0] ST_GOT_ALARM  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_MESSAGE = 3'd4;

	typedef struct packed {
		logic              op;
		logic              kind;
		logic [DATA_W-1:0] payload;
	} apmq_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] data_out;
		logic [HELD_W-1:0] held_count;
		logic              alarm_pending;
	} apmq_rsp_t;

endpackage

FILE: hdl/apmq_core.sv
// ----------------------------------------------------------------------------
// apmq_core: queue state and per-request update
// Holds the normal ring, its pointers and count, and the alarm slot; builds
// the response for the current request and commits the state change on fire.
// ----------------------------------------------------------------------------
module apmq_core
	import apmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  apmq_req_t req,
	output apmq_rsp_t rsp
);

	logic [PAYLOAD_WIDTH-1:0] store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [CNT_W-1:0]         count_q;
	logic                     alarm_valid_q;
	logic [PAYLOAD_WIDTH-1:0] alarm_msg_q;

	logic [PAYLOAD_WIDTH-1:0] pay;
	logic                     push;
	logic                     pop;
	logic                     alarm_set;
	logic                     alarm_clr;
	logic [CNT_W-1:0]         count_d;
	logic                     alarm_valid_d;
	logic [CNT_W:0]           held_sum;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign pay = PAYLOAD_WIDTH'(req.payload);

	always_comb begin
		push          = 1'b0;
		pop           = 1'b0;
		alarm_set     = 1'b0;
		alarm_clr     = 1'b0;
		rsp.status    = ST_NO_MESSAGE;
		rsp.data_out  = '0;
		if (req.op == OP_SEND) begin
			if (req.kind == KIND_ALARM) begin
				if (alarm_valid_q) begin
					rsp.status = ST_NO_ROOM;
				end else begin
					alarm_set  = 1'b1;
					rsp.status = ST_SENT;
				end
			end else begin
				if (count_q == CNT_W'(QUEUE_DEPTH)) begin
					rsp.status = ST_NO_ROOM;
				end else begin
					push       = 1'b1;
					rsp.status = ST_SENT;
				end
			end
		end else begin
			if (alarm_valid_q) begin
				alarm_clr    = 1'b1;
				rsp.status   = ST_GOT_ALARM;
				rsp.data_out = DATA_W'(alarm_msg_q);
			end else if (count_q != '0) begin
				pop          = 1'b1;
				rsp.status   = ST_GOT_NORMAL;
				rsp.data_out = DATA_W'(store_q[rd_ptr_q]);
			end
		end

		count_d = count_q;
		if (push) begin
			count_d = count_q + 1'b1;
		end else if (pop) begin
			count_d = count_q - 1'b1;
		end
		alarm_valid_d = (alarm_valid_q | alarm_set) & ~alarm_clr;

		held_sum          = {1'b0, count_d} + (CNT_W + 1)'(alarm_valid_d);
		rsp.held_count    = HELD_W'(held_sum);
		rsp.alarm_pending = alarm_valid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			count_q       <= '0;
			alarm_valid_q <= 1'b0;
			alarm_msg_q   <= '0;
		end else if (fire) begin
			count_q       <= count_d;
			alarm_valid_q <= alarm_valid_d;
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (alarm_set) begin
				alarm_msg_q <= pay;
			end else if (alarm_clr) begin
				alarm_msg_q <= '0;
			end
		end
	end

	// Ring entries carry no reset; an entry is read only after it was written.
	always_ff @(posedge clk) begin
		if (fire && push) begin
			store_q[wr_ptr_q] <= pay;
		end
	end

endmodule

FILE: hdl/alarm_priority_message_queue.sv
// ----------------------------------------------------------------------------
// alarm_priority_message_queue: message queue with one alarm priority slot
// Stream front end around the queue core: request register, single-pass
// update, result register.
// ----------------------------------------------------------------------------
// Every request on the slave stream (send or receive) returns exactly one
// result on the master stream, in request order. A request is captured in
// the request register, evaluated combinationally against the queue state,
// and its result is registered in the result register once that register
// is free or being drained. One request per cycle is sustained while the
// master stream does not stall: pointers, the normal count and the alarm
// slot all update in the same cycle that the result is registered, so the
// next request sees the new state at once.
// Sends of a normal message are refused with no room when the ring holds
// QUEUE_DEPTH entries; a second alarm is refused while the slot is full.
// A receive returns the pending alarm first, then normal messages oldest
// first, or no message. No clearing pass is needed after reset.
module alarm_priority_message_queue
	import apmq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] payload
	input  logic [1:0]  s_tuser,   // [0] op, [1] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] data_out, [36:32] held_count,
	                               // [37] alarm_pending, [39:38] zero
	output logic [2:0]  m_tuser    // [2:0] status
);

	apmq_req_t req_s1;
	logic      valid_s1;
	apmq_rsp_t rsp;
	apmq_rsp_t rsp_s2;
	logic      valid_s2;
	logic      fire;

	// Advance the request into the result register when that slot is free
	// or being drained this cycle.
	assign fire     = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold request payload until it moves on.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.op      <= s_tuser[0];
			req_s1.kind    <= s_tuser[1];
			req_s1.payload <= s_tdata;
		end
	end

	apmq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = rsp_s2.status;
	assign m_tdata  = {2'b00, rsp_s2.alarm_pending, rsp_s2.held_count, rsp_s2.data_out};

	// An empty result register never stalls the request side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request side stalled with empty result register");

	// Taking the alarm leaves no alarm pending.
	a_alarm_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_GOT_ALARM) |-> !m_tdata[37])
		else $error("alarm still pending after alarm receive");

	// Data is zero unless a message was received.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_SENT || m_tuser == ST_NO_ROOM ||
			m_tuser == ST_NO_MESSAGE)) |-> (m_tdata[31:0] == 32'd0))
		else $error("nonzero data on a result without a message");

	// No message means the queue is empty.
	a_empty_on_none: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_NO_MESSAGE) |->
			(m_tdata[36:32] == 5'd0 && !m_tdata[37]))
		else $error("no-message status while messages are held");

endmodule

FILE: tb/alarm_priority_message_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_priority_message_queue_test: stream-level check of the message queue
// Drives send and receive requests through bursty traffic against a stalling
// receiver, predicts each result from a behavioral copy of the queue and the
// alarm slot, and compares every returned result field by field, in order.
// ----------------------------------------------------------------------------
module alarm_priority_message_queue_test;
	import apmq_pkg::*;

	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1800;
	localparam int SEGMENT_LEN  = 40;
	// Longest legal quiet stretch is a sender gap or a receiver stall; the limit
	// lies well beyond it before calling the run hung.
	localparam int IDLE_LIMIT   = 2000;
	// Linger a little past the last result so that any stray extra result gets
	// caught.
	localparam int DRAIN_CYCLES = 8;

	localparam logic [DATA_W-1:0] PAYLOAD_MASK = {PAYLOAD_WIDTH{1'b1}};

	typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] payload
	logic [1:0]  s_tuser  = '0;   // [0] op, [1] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [31:0] data_out, [36:32] held_count,
	                              // [37] alarm_pending, [39:38] zero
	logic [2:0]  m_tuser;         // [2:0] status

	alarm_priority_message_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Requests waiting to be offered, and results owed by the block in order.
	apmq_req_t pending_requests[$];
	apmq_rsp_t expected_replies[$];

	int  total_requests = 0;
	int  accepted       = 0;
	int  mismatches     = 0;
	int  idle_cycles    = 0;
	bit  req_fire       = 1'b0;
	bit  timed_out      = 1'b0;

	// Behavioral image of the queue: normal ring plus the single alarm slot.
	logic [DATA_W-1:0] ring [QUEUE_DEPTH];
	int                ring_rd    = 0;
	int                ring_wr    = 0;
	int                ring_count = 0;
	logic              alarm_held = 1'b0;
	logic [DATA_W-1:0] alarm_word = '0;

	// Sender burst shaping and receiver stall pattern.
	int          burst_left  = 8;
	int          gap_left    = 0;
	ready_mode_t ready_mode  = READY_ALWAYS;
	int          ready_phase = 0;
	logic [7:0]  ready_mask  = 8'hff;

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one request to the queue image and return the result it owes.
	function automatic apmq_rsp_t predict_reply(apmq_req_t req);
		apmq_rsp_t         rsp;
		logic [DATA_W-1:0] word;
		rsp  = '0;
		word = req.payload & PAYLOAD_MASK;
		if (req.op == OP_SEND) begin
			if (req.kind == KIND_ALARM) begin
				// Refuse a second alarm while the slot is taken.
				if (alarm_held) begin
					rsp.status = ST_NO_ROOM;
				end else begin
					alarm_word = word;
					alarm_held = 1'b1;
					rsp.status = ST_SENT;
				end
			end else if (ring_count >= QUEUE_DEPTH) begin
				rsp.status = ST_NO_ROOM;
			end else begin
				ring[ring_wr] = word;
				ring_wr       = (ring_wr + 1) % QUEUE_DEPTH;
				ring_count++;
				rsp.status    = ST_SENT;
			end
		end else if (alarm_held) begin
			// Alarm jumps ahead of any normal message.
			rsp.data_out = alarm_word;
			alarm_held   = 1'b0;
			alarm_word   = '0;
			rsp.status   = ST_GOT_ALARM;
		end else if (ring_count > 0) begin
			rsp.data_out = ring[ring_rd];
			ring_rd      = (ring_rd + 1) % QUEUE_DEPTH;
			ring_count--;
			rsp.status   = ST_GOT_NORMAL;
		end else begin
			rsp.status = ST_NO_MESSAGE;
		end
		// Held count wraps at the field width.
		rsp.held_count    = HELD_W'(ring_count + int'(alarm_held));
		rsp.alarm_pending = alarm_held;
		return rsp;
	endfunction

	task automatic queue_request(logic op, logic kind, logic [DATA_W-1:0] payload);
		apmq_req_t req;
		req.op      = op;
		req.kind    = kind;
		req.payload = payload;
		pending_requests.push_back(req);
		total_requests++;
	endtask

	// Lean on the all-zero and all-one handles now and then.
	function automatic logic [DATA_W-1:0] random_payload();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: sample both handshakes at the rising edge. Retire the result
	// before recording the new request, since a result can never belong to
	// a request accepted at the same edge.
	always @(posedge clk) begin
		apmq_rsp_t got;
		apmq_rsp_t want;
		apmq_req_t req;
		if (arst_n) begin
			req_fire = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.status        = m_tuser;
				got.data_out      = m_tdata[31:0];
				got.held_count    = m_tdata[36:32];
				got.alarm_pending = m_tdata[37];
				if (expected_replies.size() == 0) begin
					$error("unexpected result: status %0d, data_out %0h",
						got.status, got.data_out);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("data_out", want.data_out, got.data_out);
					check_field("held_count", 32'(want.held_count),
						32'(got.held_count));
					check_field("alarm_pending", 32'(want.alarm_pending),
						32'(got.alarm_pending));
				end
			end
			if (req_fire) begin
				req.op      = s_tuser[0];
				req.kind    = s_tuser[1];
				req.payload = s_tdata;
				expected_replies.push_back(predict_reply(req));
				accepted++;
			end
			// Watchdog: count edges where neither side moves anything.
			if (req_fire || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Driver: at the falling edge, advance to the next request only once the
	// current one has been taken. Work in bursts separated by random gaps.
	always @(negedge clk) begin
		apmq_req_t req;
		if (arst_n && (!s_tvalid || req_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				req = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= req.payload;
				s_tuser  <= {req.kind, req.op};
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					// Mix back-to-back bursts with short and long gaps.
					case ($urandom_range(0, 3))
						0:       gap_left = 0;
						1:       gap_left = 1;
						2:       gap_left = $urandom_range(2, 4);
						default: gap_left = $urandom_range(5, 12);
					endcase
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch between always ready, coin-flip ready and a rotating
	// eight-bit stall mask. Keep one mask bit set so a stall never lasts.
	always @(negedge clk) begin
		if (ready_phase == 0) begin
			ready_mode  = ready_mode_t'($urandom_range(0, 2));
			ready_mask  = 8'($urandom_range(0, 255)) | 8'h01;
			ready_phase = $urandom_range(16, 96);
		end else begin
			ready_phase--;
		end
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			default: begin
				m_tready   <= ready_mask[0];
				ready_mask  = {ready_mask[0], ready_mask[7:1]};
			end
		endcase
	end

	initial begin
		int   send_pct;
		logic op_bit;
		logic kind_bit;

		send_pct = 50;

		// Directed opening: receive from an empty queue, with a payload and
		// kind that must be ignored.
		queue_request(OP_RECEIVE, KIND_ALARM, '1);
		// Take the alarm slot, then get refused for a second alarm.
		queue_request(OP_SEND, KIND_ALARM, '1);
		queue_request(OP_SEND, KIND_ALARM, 32'h1234_5678);
		// Fill the normal ring to the brim with the extremes at the ends.
		queue_request(OP_SEND, KIND_NORMAL, '0);
		for (int i = 1; i < QUEUE_DEPTH - 1; i++)
			queue_request(OP_SEND, KIND_NORMAL, random_payload());
		queue_request(OP_SEND, KIND_NORMAL, '1);
		// Full ring plus alarm: highest held count, normal send refused.
		queue_request(OP_SEND, KIND_NORMAL, 32'hdead_beef);
		// Alarm leaves first, then the oldest normal message.
		queue_request(OP_RECEIVE, KIND_NORMAL, random_payload());
		queue_request(OP_RECEIVE, KIND_ALARM, random_payload());
		// Alarm sent into a busy ring still jumps the line.
		queue_request(OP_SEND, KIND_ALARM, '0);
		queue_request(OP_RECEIVE, KIND_NORMAL, '1);
		queue_request(OP_RECEIVE, KIND_ALARM, '0);

		// Random part: vary the send share per segment so the ring swings
		// between empty and full, hitting both refusal and no-message cases.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % SEGMENT_LEN == 0) begin
				case ($urandom_range(0, 3))
					0:       send_pct = 20;
					1:       send_pct = 50;
					2:       send_pct = 80;
					default: send_pct = 95;
				endcase
			end
			op_bit = ($urandom_range(0, 99) < send_pct) ? OP_SEND : OP_RECEIVE;
			if (op_bit == OP_SEND)
				kind_bit = ($urandom_range(0, 99) < 25) ? KIND_ALARM : KIND_NORMAL;
			else
				kind_bit = 1'($urandom_range(0, 1));
			queue_request(op_bit, kind_bit, random_payload());
		end

		// Hold reset for the opening cycles and release it off the edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			begin
				wait (accepted == total_requests && expected_replies.size() == 0);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			begin
				wait (idle_cycles >= IDLE_LIMIT);
				timed_out = 1'b1;
			end
		join_any

		if (!timed_out && mismatches == 0 && expected_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
